// ----- design/plid_pkg.sv -----
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and codes for the positional list block.
// ----------------------------------------------------------------------------
`default_nettype none

package plid_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REJECT   = 2'd1,
    ST_FOUND    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD = 3'd0,
    CMD_INS  = 3'd1,
    CMD_DEL  = 3'd2,
    CMD_SRCH = 3'd3,
    CMD_SCAN = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ValW-1:0]   value;
    logic [PosW-1:0]   position;
    logic [PosW-1:0]   count;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

endpackage

`default_nettype wire

// ----- design/plid_cell.sv -----
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: holds an entry and its match flag, shifts with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module plid_cell
  import plid_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cell_cmd_t       cmd,
  input  wire logic [ValW-1:0] lower_data,   // from slot IDX-1
  input  wire logic [ValW-1:0] upper_data,   // from slot IDX+1
  input  wire logic            upper_match,  // from slot IDX+1
  output logic      [ValW-1:0] data,
  output logic                 match
);

  // 1-based position of this slot
  localparam logic [PosW-1:0] SelfPos = PosW'(IDX + 1);

  logic [ValW-1:0] data_r, data_nxt;
  logic            match_r, match_nxt;

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    case (cmd.kind)
      CMD_INS: begin
        if (cmd.position == SelfPos) begin
          data_nxt = cmd.value;
        end else if (cmd.position < SelfPos) begin
          data_nxt = lower_data;
        end
      end
      CMD_DEL: begin
        if (cmd.position <= SelfPos) begin
          data_nxt = upper_data;
        end
      end
      CMD_SRCH: begin
        match_nxt = (data_r == cmd.value) && (SelfPos <= cmd.count);
      end
      CMD_SCAN: begin
        match_nxt = upper_match;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

`default_nettype wire

// ----- design/positional_list_insert_delete_search.sv -----
// ----------------------------------------------------------------------------
// positional_list_insert_delete_search
// Ordered list of signed words with insert and delete by position and search by value.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells, one word per cell. Insert and
// delete move every later word one cell up or down together, and give one
// result beat. A search latches a match flag in every cell together, then
// shifts the flags toward cell 0 one slot per cycle while the output is not
// stalled, and gives one found beat per match (last on the final one) or one
// not-found beat. The next input beat is taken once the search has drained.
// Storage words come up undefined; only slots below list_count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete_search
  import plid_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] value, [38:32] position, [39] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [6:0] found_position, [13:7] list_count, [15:14] zero
  output logic      [1:0]  out_tuser,  // [1:0] status
  output logic             out_tlast
);

  // input beat fields
  logic [ValW-1:0] in_value;
  logic [PosW-1:0] in_pos;
  op_t             in_op;

  assign in_value = in_tdata[ValW-1:0];
  assign in_pos   = in_tdata[ValW+PosW-1:ValW];
  assign in_op    = op_t'(in_tuser);

  localparam logic [PosW-1:0] CapPos = PosW'(CAPACITY);

  // control state
  state_t          state_r, state_nxt;
  logic [PosW-1:0] count_r, count_nxt;
  logic [PosW-1:0] scan_idx_r, scan_idx_nxt;   // slots already scanned
  logic            pend_valid_r, pend_valid_nxt; // a found beat held back
  logic [PosW-1:0] pend_pos_r, pend_pos_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [PosW-1:0] out_fpos_r, out_fpos_nxt;
  logic [PosW-1:0] out_count_r, out_count_nxt;
  logic            out_last_r, out_last_nxt;

  logic            can_push;  // output slot free this cycle
  logic            in_fire;
  cell_cmd_t       cmd;

  // cell chain
  logic [ValW-1:0] cell_data  [CAPACITY];
  logic            cell_match [CAPACITY];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ValW-1:0] lo_d, up_d;
      logic            up_m;
      if (g == 0) begin : g_lo0
        assign lo_d = cell_data[g];
      end else begin : g_lo
        assign lo_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_top
        assign up_d = cell_data[g];
        assign up_m = 1'b0;
      end else begin : g_up
        assign up_d = cell_data[g+1];
        assign up_m = cell_match[g+1];
      end
      plid_cell #(.IDX(g)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .lower_data  (lo_d),
        .upper_data  (up_d),
        .upper_match (up_m),
        .data        (cell_data[g]),
        .match       (cell_match[g])
      );
    end
  endgenerate

  assign can_push  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && can_push;
  assign in_fire   = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_op == OP_SEARCH) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (can_push && scan_idx_r == count_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd.kind       = CMD_HOLD;
    cmd.value      = in_value;
    cmd.position   = in_pos;
    cmd.count      = count_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_pos_nxt   = pend_pos_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_fpos_nxt   = out_fpos_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_INSERT: begin
              out_valid_nxt  = 1'b1;
              out_fpos_nxt   = '0;
              out_last_nxt   = 1'b1;
              if (count_r >= CapPos || in_pos == '0 || in_pos > count_r + 1'b1) begin
                out_status_nxt = ST_REJECT;
                out_count_nxt  = count_r;
              end else begin
                cmd.kind       = CMD_INS;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = ST_DONE;
                out_count_nxt  = count_r + 1'b1;
              end
            end
            OP_DELETE: begin
              out_valid_nxt  = 1'b1;
              out_fpos_nxt   = '0;
              out_last_nxt   = 1'b1;
              if (in_pos == '0 || in_pos > count_r) begin
                out_status_nxt = ST_REJECT;
                out_count_nxt  = count_r;
              end else begin
                cmd.kind       = CMD_DEL;
                count_nxt      = count_r - 1'b1;
                out_status_nxt = ST_DONE;
                out_count_nxt  = count_r - 1'b1;
              end
            end
            OP_SEARCH: begin
              // latch match flags, results come from the scan
              cmd.kind       = CMD_SRCH;
              scan_idx_nxt   = '0;
              pend_valid_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_REJECT;
              out_fpos_nxt   = '0;
              out_count_nxt  = count_r;
              out_last_nxt   = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (can_push) begin
          if (scan_idx_r == count_r) begin
            // end of list: flush held match as last, or report none
            out_valid_nxt  = 1'b1;
            out_count_nxt  = count_r;
            out_last_nxt   = 1'b1;
            if (pend_valid_r) begin
              out_status_nxt = ST_FOUND;
              out_fpos_nxt   = pend_pos_r;
            end else begin
              out_status_nxt = ST_NOTFOUND;
              out_fpos_nxt   = '0;
            end
          end else begin
            cmd.kind     = CMD_SCAN;
            scan_idx_nxt = scan_idx_r + 1'b1;
            if (cell_match[0]) begin
              // a newer match exists, so the held one is not last
              if (pend_valid_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FOUND;
                out_fpos_nxt   = pend_pos_r;
                out_count_nxt  = count_r;
                out_last_nxt   = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_pos_nxt   = scan_idx_r + 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      scan_idx_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      scan_idx_r   <= scan_idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_pos_r   <= pend_pos_nxt;
    out_status_r <= out_status_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_fpos_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: positional list insert / delete / search
// A directed list of beats covers the edge cases. Random traffic then fills
// the list, searches it while it is full, and drains it again. A scoreboard
// keeps a shadow copy of the list and checks every result beat, field by
// field, against the predicted beats.
// ----------------------------------------------------------------------------

import plid_pkg::*;

localparam int unsigned LIST_DEPTH = 64;

typedef struct {
  status_t    status;
  logic [6:0] found_pos;
  logic [6:0] count;
  logic       last;
} list_result_t;

class list_scoreboard;
  logic signed [31:0] shadow_list[$];
  list_result_t       expected_q[$];
  int                 mismatches;

  function int unsigned depth();
    return shadow_list.size();
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // Apply one accepted input beat to the shadow list and queue its results.
  function void note_item(op_t op, logic signed [31:0] val, logic [6:0] pos);
    int unsigned  n;
    int           hits;
    status_t      st;
    list_result_t r;
    n    = shadow_list.size();
    hits = 0;
    st   = ST_REJECT;
    case (op)
      OP_INSERT: begin
        if (n < LIST_DEPTH && pos >= 1 && pos <= n + 1) begin
          shadow_list.insert(int'(pos) - 1, val);
          st = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (pos >= 1 && pos <= n) begin
          shadow_list.delete(int'(pos) - 1);
          st = ST_DONE;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < n; i++) begin
          if (shadow_list[i] == val) begin
            r.status    = ST_FOUND;
            r.found_pos = 7'(i + 1);
            r.count     = 7'(n);
            r.last      = 1'b0;
            expected_q.push_back(r);
            hits++;
          end
        end
        if (hits > 0) begin
          expected_q[expected_q.size() - 1].last = 1'b1;
          return;
        end
        st = ST_NOTFOUND;
      end
      default: st = ST_REJECT;
    endcase
    r.status    = st;
    r.found_pos = 7'd0;
    r.count     = 7'(shadow_list.size());
    r.last      = 1'b1;
    expected_q.push_back(r);
  endfunction

  function void check_beat(status_t st, logic [6:0] fpos, logic [6:0] cnt, logic last);
    list_result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result beat with nothing expected: status %s pos %0d count %0d last %0b",
                 $realtime, st.name(), fpos, cnt, last);
      return;
    end
    e = expected_q.pop_front();
    if (st !== e.status || fpos !== e.found_pos || cnt !== e.count || last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp status %s pos %0d count %0d last %0b, got %s %0d %0d %0b",
                 $realtime, e.status.name(), e.found_pos, e.count, e.last,
                 st.name(), fpos, cnt, last);
    end
  endfunction
endclass

module tb;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [31:0] value, [38:32] position, [39] zero
  logic [1:0]  in_tuser   = '0;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [6:0] found_position, [13:7] list_count, [15:14] zero
  logic [1:0]  out_tuser;         // [1:0] status
  logic        out_tlast;

  // Both sides consult this to decide whether to throw in idle bursts.
  bit idle_on = 1'b0;

  list_scoreboard sb = new;

  always #6 clk = ~clk;

  positional_list_insert_delete_search #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Drive one input beat and hold it until the block takes it. tvalid is left
  // high on return so back-to-back beats need no extra NBA in the same step.
  task automatic send_item(op_t op, logic signed [31:0] val, logic [6:0] pos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, pos, val};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, val, pos);
  endtask

  // Drop tvalid and hold off until every predicted result beat has drained.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Receiver backpressure: random stall bursts while idling is on.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result monitor; values sampled at the edge are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(status_t'(out_tuser), out_tdata[6:0], out_tdata[13:7], out_tlast);
  end

  initial begin
    logic signed [31:0] pool[6];
    logic signed [31:0] val;
    logic [6:0]         pos;
    op_t                op;
    int unsigned        r;
    int unsigned        n;

    pool[0] = 32'sd0;
    pool[1] = -32'sd1;
    pool[2] = 32'h8000_0000;
    pool[3] = 32'h7FFF_FFFF;
    pool[4] = $urandom;
    pool[5] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, bad positions, list ends, duplicates, unused code.
    idle_on = 1'b1;
    send_item(OP_SEARCH, 32'sd0, 7'd1);          // search on empty list
    send_item(OP_DELETE, 32'sd0, 7'd1);          // delete on empty list
    send_item(OP_INSERT, 32'sd9, 7'd0);          // position zero
    send_item(OP_INSERT, 32'sd9, 7'd2);          // past count + 1
    send_item(OP_INSERT, 32'h7FFF_FFFF, 7'd1);
    send_item(OP_INSERT, 32'h8000_0000, 7'd1);   // at the head
    send_item(OP_INSERT, 32'sd5, 7'd3);          // at the tail
    send_item(OP_INSERT, 32'sd5, 7'd2);          // in the middle
    send_item(OP_INSERT, 32'sd5, 7'h7F);         // all-ones position
    send_item(OP_SEARCH, 32'sd5, 7'd0);          // two matches
    send_item(OP_SEARCH, 32'h8000_0000, 7'h7F);
    send_item(OP_SEARCH, 32'h7FFF_FFFF, 7'd3);
    send_item(OP_SEARCH, 32'sd0, 7'd0);          // no match
    send_item(OP_RSVD, -32'sd1, 7'h7F);          // unused operation code
    send_item(OP_DELETE, 32'sd0, 7'd0);
    send_item(OP_DELETE, 32'sd0, 7'd5);          // count + 1
    send_item(OP_DELETE, -32'sd1, 7'd2);
    send_item(OP_DELETE, 32'sd0, 7'd3);          // tail
    send_item(OP_DELETE, 32'sd0, 7'd1);          // head
    send_item(OP_SEARCH, 32'sd5, 7'd0);
    send_item(OP_INSERT, -32'sd1, 7'd2);
    send_item(OP_SEARCH, -32'sd1, 7'd0);
    send_item(OP_DELETE, 32'sd0, 7'd64);         // position bit 6

    // Random: fill to capacity, search the full list, then drain it.
    for (int i = 0; i < 230; i++) begin
      // stretches with and without idling; none at all in the last part
      idle_on = (i < 190) && ((i / 25) % 3 != 2);
      // once, hold the sender until the block has fully caught up
      if (i == 90)
        wait_drained();

      r = $urandom_range(0, 99);
      if (r < 2)
        op = OP_RSVD;
      else if (i < 90)
        op = (r < 88) ? OP_INSERT : (r < 93) ? OP_DELETE : OP_SEARCH;
      else if (i < 150)
        op = (r < 27) ? OP_INSERT : (r < 47) ? OP_DELETE : OP_SEARCH;
      else
        op = (r < 12) ? OP_INSERT : (r < 82) ? OP_DELETE : OP_SEARCH;

      // mostly repeated values so searches hit several positions
      val = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 5)] : $urandom;

      n = sb.depth();
      if (op == OP_INSERT && $urandom_range(0, 99) < 88)
        pos = 7'($urandom_range(1, n + 1));
      else if (op == OP_DELETE && n > 0 && $urandom_range(0, 99) < 88)
        pos = 7'($urandom_range(1, n));
      else
        pos = 7'($urandom_range(0, 127));

      send_item(op, val, pos);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog, well above the slowest legal run (every search draining 64
  // beats against the longest receiver stalls).
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
